### rtl/variable_bin_lookup_defines.svh
// Assertion macros for the bin lookup block
`ifndef VARIABLE_BIN_LOOKUP_DEFINES_SVH
`define VARIABLE_BIN_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define VBL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define VBL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/vbl_pkg.sv
`default_nettype none

package vbl_pkg;

	localparam int MAX_BINS    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int DEPTH       = MAX_BINS + 1;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CMP_W       = CNT_W + 1;
	localparam int IDX_W       = 7;
	localparam int BIN_W       = 6;
	localparam int REQ_W       = 2;
	localparam int STAT_W      = 2;
	localparam int NB_W        = 7;
	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	localparam logic [PADDR_W-1:0] ADDR_NUM_BINS = '0;
	localparam logic [NB_W-1:0]    NUM_BINS_RST  = NB_W'(1);

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE = 2'd0,
		REQ_FIND  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_INDEX  = 2'd1,
		ST_NOT_INCR   = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_W_CHK  = 7'b0000010,
		S_L_MIN  = 7'b0000100,
		S_L_MAX  = 7'b0001000,
		S_L_SRCH = 7'b0010000,
		S_B_LO   = 7'b0100000,
		S_B_HI   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic                   we;
		logic [ADDR_W-1:0]      waddr;
		logic [VALUE_WIDTH-1:0] wdata;
		logic                   re;
		logic [ADDR_W-1:0]      raddr;
	} mem_req_t;

	function automatic logic [CNT_W-1:0] bins_in_use(input logic [NB_W-1:0] nb);
		logic [CNT_W-1:0] n;
		n = CNT_W'(nb);
		if (nb == '0) begin
			n = CNT_W'(1);
		end else if (CMP_W'(nb) > CMP_W'(MAX_BINS)) begin
			n = CNT_W'(MAX_BINS);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/vbl_edge_mem.sv
`default_nettype none

module vbl_edge_mem (
	input  wire logic                           clk,
	input  wire vbl_pkg::mem_req_t              mem_req,
	output logic [vbl_pkg::VALUE_WIDTH-1:0]     rd_data
);

	logic [vbl_pkg::VALUE_WIDTH-1:0] mem_q [vbl_pkg::DEPTH];
	logic [vbl_pkg::VALUE_WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_q <= mem_q[mem_req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

### rtl/variable_bin_lookup.sv
// Bin lookup over a table of strictly increasing signed edges. A request is
// taken at a clock edge where start is high and busy is low; its single result
// appears on status, bin_index, lower_edge, upper_edge and center for exactly
// one cycle with done high, and the receiver cannot stall it, so capture it
// then. Rejected requests and a write at index 0 are answered straight from
// idle; other writes pass through a check state, a bin read fetches its low and
// high edges, and a lookup probes the first and, unless clamped, the last edge,
// then runs its search steps (at most ceil(log2(num_bins))) and fetches the edges.
// Every edge read goes through the single read port of the edge memory and one shared
// signed comparator, one read per cycle. busy stays high until the result is
// issued; a new request may be taken in the cycle done is high. num_bins must be
// written over the APB port only while the block is idle; the block does not enforce it.
`default_nettype none

`include "variable_bin_lookup_defines.svh"

module variable_bin_lookup (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [vbl_pkg::REQ_W-1:0]        req_type,
	input  wire logic [vbl_pkg::IDX_W-1:0]        index,
	input  wire logic signed [vbl_pkg::VALUE_WIDTH-1:0] value,
	output logic                                  done,
	output logic [vbl_pkg::STAT_W-1:0]            status,
	output logic [vbl_pkg::BIN_W-1:0]             bin_index,
	output logic signed [vbl_pkg::VALUE_WIDTH-1:0] lower_edge,
	output logic signed [vbl_pkg::VALUE_WIDTH-1:0] upper_edge,
	output logic signed [vbl_pkg::VALUE_WIDTH-1:0] center,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [vbl_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [vbl_pkg::PDATA_W-1:0]      pwdata,
	output logic [vbl_pkg::PDATA_W-1:0]           prdata,
	output logic                                  pready
);

	localparam int VW    = vbl_pkg::VALUE_WIDTH;
	localparam int CNT_W = vbl_pkg::CNT_W;
	localparam int CMP_W = vbl_pkg::CMP_W;
	localparam int AW    = vbl_pkg::ADDR_W;

	vbl_pkg::state_t state_q, state_d;

	logic [vbl_pkg::NB_W-1:0] num_bins_q;
	logic [CNT_W-1:0]         el_q, el_d;
	logic [CNT_W-1:0]         n_q, n_d;
	logic [vbl_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [VW-1:0]            v_q, v_d;
	logic [CNT_W-1:0]         lo_q, lo_d;
	logic [CNT_W-1:0]         hi_q, hi_d;
	logic [CNT_W-1:0]         mid_q, mid_d;
	logic [VW-1:0]            edge_lo_q, edge_lo_d;

	logic                        done_q, done_d;
	logic [vbl_pkg::STAT_W-1:0]  status_q, status_d;
	logic [vbl_pkg::BIN_W-1:0]   bin_q, bin_d;
	logic [VW-1:0]               lower_q, lower_d;
	logic [VW-1:0]               upper_q, upper_d;
	logic [VW-1:0]               center_q, center_d;

	vbl_pkg::mem_req_t mem_req;
	logic [VW-1:0]     rd_data;

	logic [CNT_W-1:0] n_cur;
	logic [CMP_W-1:0] idx_x, n_x, el_x;
	logic             le, eq;
	logic [CNT_W-1:0] lo_n, hi_n, mid_n;
	logic [CNT_W:0]   mid_sum;
	logic [VW:0]      ctr_sum;
	logic             cfg_wr;
	logic             res_clear;
	logic             probe_ok;

	vbl_edge_mem u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	assign busy  = (state_q != vbl_pkg::S_IDLE);
	assign n_cur = vbl_pkg::bins_in_use(num_bins_q);
	assign idx_x = CMP_W'(index);
	assign n_x   = CMP_W'(n_cur);
	assign el_x  = CMP_W'(el_q);

	// shared comparator: stored edge against the held value
	assign le = ($signed(rd_data) <= $signed(v_q));
	assign eq = (rd_data == v_q);

	assign lo_n    = le ? mid_q : lo_q;
	assign hi_n    = le ? hi_q : mid_q;
	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = mid_sum[CNT_W:1];

	assign ctr_sum = {edge_lo_q[VW-1], edge_lo_q} + {rd_data[VW-1], rd_data};

	always_comb begin
		state_d   = state_q;
		el_d      = el_q;
		n_d       = n_q;
		idx_d     = idx_q;
		v_d       = v_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		edge_lo_d = edge_lo_q;
		mem_req   = '0;
		done_d    = 1'b0;
		status_d  = vbl_pkg::ST_OK;
		bin_d     = '0;
		lower_d   = '0;
		upper_d   = '0;
		center_d  = '0;
		case (state_q)
			vbl_pkg::S_IDLE: begin
				if (start) begin
					idx_d = index;
					v_d   = value;
					n_d   = n_cur;
					case (vbl_pkg::req_t'(req_type))
						vbl_pkg::REQ_WRITE: begin
							if (idx_x > n_x || idx_x > el_x) begin
								done_d   = 1'b1;
								status_d = vbl_pkg::ST_BAD_INDEX;
							end else if (index == '0) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = AW'(index);
								mem_req.wdata = value;
								el_d          = CNT_W'(idx_x + CMP_W'(1));
								done_d        = 1'b1;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = AW'(idx_x - CMP_W'(1));
								state_d       = vbl_pkg::S_W_CHK;
							end
						end
						vbl_pkg::REQ_FIND: begin
							if (el_x < n_x + CMP_W'(1)) begin
								done_d   = 1'b1;
								status_d = vbl_pkg::ST_INCOMPLETE;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = '0;
								state_d       = vbl_pkg::S_L_MIN;
							end
						end
						vbl_pkg::REQ_READ: begin
							if (idx_x >= n_x) begin
								done_d   = 1'b1;
								status_d = vbl_pkg::ST_BAD_INDEX;
							end else if (el_x < idx_x + CMP_W'(2)) begin
								done_d   = 1'b1;
								status_d = vbl_pkg::ST_INCOMPLETE;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = AW'(index);
								lo_d          = CNT_W'(index);
								state_d       = vbl_pkg::S_B_LO;
							end
						end
						default: begin
							done_d   = 1'b1;
							status_d = vbl_pkg::ST_BAD_INDEX;
						end
					endcase
				end
			end
			vbl_pkg::S_W_CHK: begin
				done_d = 1'b1;
				if (le && !eq) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = AW'(idx_q);
					mem_req.wdata = v_q;
					el_d          = CNT_W'(CMP_W'(idx_q) + CMP_W'(1));
				end else begin
					status_d = vbl_pkg::ST_NOT_INCR;
				end
				state_d = vbl_pkg::S_IDLE;
			end
			vbl_pkg::S_L_MIN: begin
				mem_req.re = 1'b1;
				if (!le) begin
					// below the first edge: clamp to bin 0
					lo_d          = '0;
					mem_req.raddr = '0;
					state_d       = vbl_pkg::S_B_LO;
				end else begin
					mem_req.raddr = AW'(n_q);
					state_d       = vbl_pkg::S_L_MAX;
				end
			end
			vbl_pkg::S_L_MAX: begin
				mem_req.re = 1'b1;
				if (le) begin
					// at or above the last edge: clamp to the last bin
					lo_d          = n_q - CNT_W'(1);
					mem_req.raddr = AW'(n_q - CNT_W'(1));
					state_d       = vbl_pkg::S_B_LO;
				end else begin
					lo_d = '0;
					hi_d = n_q;
					if (n_q > CNT_W'(1)) begin
						mid_d         = n_q >> 1;
						mem_req.raddr = AW'(n_q >> 1);
						state_d       = vbl_pkg::S_L_SRCH;
					end else begin
						mem_req.raddr = '0;
						state_d       = vbl_pkg::S_B_LO;
					end
				end
			end
			vbl_pkg::S_L_SRCH: begin
				lo_d       = lo_n;
				hi_d       = hi_n;
				mem_req.re = 1'b1;
				if (hi_n - lo_n > CNT_W'(1)) begin
					mid_d         = mid_n;
					mem_req.raddr = AW'(mid_n);
				end else begin
					mem_req.raddr = AW'(lo_n);
					state_d       = vbl_pkg::S_B_LO;
				end
			end
			vbl_pkg::S_B_LO: begin
				edge_lo_d     = rd_data;
				mem_req.re    = 1'b1;
				mem_req.raddr = AW'(lo_q + CNT_W'(1));
				state_d       = vbl_pkg::S_B_HI;
			end
			vbl_pkg::S_B_HI: begin
				done_d   = 1'b1;
				bin_d    = lo_q[vbl_pkg::BIN_W-1:0];
				lower_d  = edge_lo_q;
				upper_d  = rd_data;
				center_d = ctr_sum[VW:1];
				state_d  = vbl_pkg::S_IDLE;
			end
			default: begin
				state_d = vbl_pkg::S_IDLE;
			end
		endcase
	end

	assign cfg_wr = psel && penable && pwrite && pready && (paddr == vbl_pkg::ADDR_NUM_BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vbl_pkg::S_IDLE;
			el_q       <= '0;
			num_bins_q <= vbl_pkg::NUM_BINS_RST;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			el_q    <= el_d;
			done_q  <= done_d;
			if (cfg_wr) begin
				num_bins_q <= pwdata[vbl_pkg::NB_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q       <= n_d;
		idx_q     <= idx_d;
		v_q       <= v_d;
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		mid_q     <= mid_d;
		edge_lo_q <= edge_lo_d;
		if (done_d) begin
			status_q <= status_d;
			bin_q    <= bin_d;
			lower_q  <= lower_d;
			upper_q  <= upper_d;
			center_q <= center_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign bin_index  = bin_q;
	assign lower_edge = lower_q;
	assign upper_edge = upper_q;
	assign center     = center_q;

	assign pready = 1'b1;
	assign prdata = (paddr == vbl_pkg::ADDR_NUM_BINS) ? vbl_pkg::PDATA_W'(num_bins_q) : '0;

	assign res_clear = bin_q == '0 && lower_q == '0 && upper_q == '0 && center_q == '0;
	assign probe_ok  = hi_q - lo_q > CNT_W'(1) && mid_q > lo_q && mid_q < hi_q;

	`VBL_ASSERT_NEXT(a_hi_then_done, state_q == vbl_pkg::S_B_HI, done_q, "fetch without result")
	`VBL_ASSERT_IMPL(a_err_clear, done_q && status_q != vbl_pkg::ST_OK, res_clear, "error payload")
	`VBL_ASSERT_IMPL(a_search_span, state_q == vbl_pkg::S_L_SRCH, probe_ok, "probe out of bounds")

endmodule

`default_nettype wire

### tb/tb_variable_bin_lookup.sv
module tb_variable_bin_lookup;
	import vbl_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int ITEM_TARGET = 1950;
	localparam int CALM_FROM = 1750;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint VMAX = 64'sd2147483647;
	localparam logic [VALUE_WIDTH-1:0] VMINV = 32'h8000_0000;
	localparam logic [VALUE_WIDTH-1:0] VMAXV = 32'h7fff_ffff;

	typedef struct packed {
		logic [STAT_W-1:0]      st;
		logic [BIN_W-1:0]       bin;
		logic [VALUE_WIDTH-1:0] lo;
		logic [VALUE_WIDTH-1:0] hi;
		logic [VALUE_WIDTH-1:0] ctr;
	} bin_answer_t;

	typedef struct {
		bit                     is_cfg;
		req_t                   req;
		logic [IDX_W-1:0]       idx;
		logic [VALUE_WIDTH-1:0] val;
		bit                     typed;
		bin_answer_t            ans;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [REQ_W-1:0]              req_type;
	logic [IDX_W-1:0]              index;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          done;
	logic [STAT_W-1:0]             status;
	logic [BIN_W-1:0]              bin_index;
	logic signed [VALUE_WIDTH-1:0] lower_edge;
	logic signed [VALUE_WIDTH-1:0] upper_edge;
	logic signed [VALUE_WIDTH-1:0] center;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [PADDR_W-1:0]            paddr;
	logic [PDATA_W-1:0]            pwdata;
	logic [PDATA_W-1:0]            prdata;
	logic                          pready;

	logic signed [VALUE_WIDTH-1:0] bound_tbl [0:MAX_BINS];
	int                            bounds_loaded;
	logic [NB_W-1:0]               nbins_reg;

	bin_answer_t                   pending_answers[$];
	stim_row_t                     dir_tbl[$];
	bit                            row_typed;
	bin_answer_t                   row_ans;
	int                            mismatch_cnt;
	int                            items_sent;
	int                            cycle_cnt;
	bit                            idle_on;

	logic signed [VALUE_WIDTH-1:0] gen_bounds [0:MAX_BINS];
	int                            gen_top;

	variable_bin_lookup uut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int active_bins();
		if (nbins_reg == '0) begin
			return 1;
		end
		if (int'(nbins_reg) > MAX_BINS) begin
			return MAX_BINS;
		end
		return int'(nbins_reg);
	endfunction

	function automatic bin_answer_t bin_of(input int b);
		bin_answer_t a;
		longint sum;
		a.st = ST_OK;
		a.bin = BIN_W'(b);
		a.lo = bound_tbl[b];
		a.hi = bound_tbl[b + 1];
		sum = longint'(bound_tbl[b]) + longint'(bound_tbl[b + 1]);
		a.ctr = VALUE_WIDTH'(sum >>> 1);
		return a;
	endfunction

	function automatic bin_answer_t answer_for(input logic [REQ_W-1:0] rq,
			input logic [IDX_W-1:0] ix, input logic signed [VALUE_WIDTH-1:0] v);
		bin_answer_t a;
		int n, i, lo_i, hi_i, mid;
		a = '0;
		n = active_bins();
		i = int'(ix);
		case (rq)
			REQ_WRITE: begin
				if (i > n || i > bounds_loaded) begin
					a.st = ST_BAD_INDEX;
				end else if (i > 0 && v <= bound_tbl[i - 1]) begin
					a.st = ST_NOT_INCR;
				end else begin
					bound_tbl[i] = v;
					bounds_loaded = i + 1;
				end
			end
			REQ_FIND: begin
				if (bounds_loaded < n + 1) begin
					a.st = ST_INCOMPLETE;
				end else if (v < bound_tbl[0]) begin
					a = bin_of(0);
				end else if (bound_tbl[n] <= v) begin
					a = bin_of(n - 1);
				end else begin
					lo_i = 0;
					hi_i = n;
					while (hi_i - lo_i > 1) begin
						mid = (lo_i + hi_i) / 2;
						if (bound_tbl[mid] <= v) begin
							lo_i = mid;
						end else begin
							hi_i = mid;
						end
					end
					a = bin_of(lo_i);
				end
			end
			REQ_READ: begin
				if (i >= n) begin
					a.st = ST_BAD_INDEX;
				end else if (bounds_loaded < i + 2) begin
					a.st = ST_INCOMPLETE;
				end else begin
					a = bin_of(i);
				end
			end
			default: begin
				a.st = ST_BAD_INDEX;
			end
		endcase
		return a;
	endfunction

	function automatic bit note_mismatch();
		mismatch_cnt++;
		return mismatch_cnt <= 10;
	endfunction

	function automatic stim_row_t r_chk(input req_t rq, input logic [IDX_W-1:0] ix,
			input logic [VALUE_WIDTH-1:0] v, input status_t st, input logic [BIN_W-1:0] b,
			input logic [VALUE_WIDTH-1:0] lo, input logic [VALUE_WIDTH-1:0] hi,
			input logic [VALUE_WIDTH-1:0] ctr);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.req = rq;
		r.idx = ix;
		r.val = v;
		r.typed = 1'b1;
		r.ans = '{st, b, lo, hi, ctr};
		return r;
	endfunction

	function automatic stim_row_t r_pred(input req_t rq, input logic [IDX_W-1:0] ix,
			input logic [VALUE_WIDTH-1:0] v);
		stim_row_t r;
		r = r_chk(rq, ix, v, ST_OK, '0, '0, '0, '0);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t r_cfg(input logic [NB_W-1:0] nbv);
		stim_row_t r;
		r = r_pred(REQ_WRITE, '0, VALUE_WIDTH'(nbv));
		r.is_cfg = 1'b1;
		return r;
	endfunction

	always @(posedge clk) begin
		bin_answer_t got, want;
		if (arst_n) begin
			if (done) begin
				got = {status, bin_index, lower_edge, upper_edge, center};
				if (pending_answers.size() == 0) begin
					if (note_mismatch()) begin
						$display("unexpected result at %0t: st=%0d bin=%0d", $realtime,
							got.st, got.bin);
					end
				end else begin
					want = pending_answers.pop_front();
					if (got.st !== want.st || got.bin !== want.bin || got.lo !== want.lo ||
							got.hi !== want.hi || got.ctr !== want.ctr) begin
						if (note_mismatch()) begin
							$display("mismatch at %0t: want st=%0d bin=%0d lo=%0d hi=%0d ctr=%0d",
								$realtime, want.st, want.bin, $signed(want.lo),
								$signed(want.hi), $signed(want.ctr));
							$display("                    got st=%0d bin=%0d lo=%0d hi=%0d ctr=%0d",
								got.st, got.bin, $signed(got.lo), $signed(got.hi),
								$signed(got.ctr));
						end
					end
				end
			end
			if (start && !busy) begin
				want = answer_for(req_type, index, value);
				if (row_typed) begin
					want = row_ans;
				end
				pending_answers = {pending_answers, want};
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("FAIL variable_bin_lookup");
			$finish;
		end
	end

	task automatic issue(input req_t rq, input logic [IDX_W-1:0] ix,
			input logic [VALUE_WIDTH-1:0] v, input bit typed, input bin_answer_t ans);
		start <= 1'b1;
		req_type <= rq;
		index <= ix;
		value <= v;
		row_typed <= typed;
		row_ans <= ans;
		do @(posedge clk); while (busy);
		items_sent++;
		if (items_sent < CALM_FROM && idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send(input req_t rq, input logic [IDX_W-1:0] ix,
			input logic [VALUE_WIDTH-1:0] v);
		issue(rq, ix, v, 1'b0, '0);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_num_bins(input logic [NB_W-1:0] nbv);
		logic [PDATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_NUM_BINS;
		pwdata <= PDATA_W'(nbv);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		nbins_reg = nbv;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== PDATA_W'(nbv)) begin
			if (note_mismatch()) begin
				$display("num_bins readback at %0t: want %0d got %0d", $realtime, nbv, rd);
			end
		end
	endtask

	initial begin
		int k, j, n, d;
		longint cur, room;
		int unsigned sm;
		logic signed [VALUE_WIDTH-1:0] qv;
		logic [NB_W-1:0] nbv;
		bit filled;

		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_WRITE;
		index = '0;
		value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		row_typed = 1'b0;
		row_ans = '0;
		bounds_loaded = 0;
		nbins_reg = NUM_BINS_RST;
		gen_top = 0;
		idle_on = 1'b1;
		foreach (bound_tbl[i]) begin
			bound_tbl[i] = '0;
			gen_bounds[i] = '0;
		end

		dir_tbl = '{
			r_chk(REQ_FIND, 0, 0, ST_INCOMPLETE, 0, 0, 0, 0),
			r_chk(REQ_READ, 1, 0, ST_BAD_INDEX, 0, 0, 0, 0),
			r_chk(REQ_WRITE, 1, 0, ST_BAD_INDEX, 0, 0, 0, 0),
			r_chk(REQ_RSVD, 127, 32'hffff_ffff, ST_BAD_INDEX, 0, 0, 0, 0),
			r_chk(REQ_WRITE, 0, VMINV, ST_OK, 0, 0, 0, 0),
			r_chk(REQ_WRITE, 1, VMINV, ST_NOT_INCR, 0, 0, 0, 0),
			r_chk(REQ_WRITE, 1, VMAXV, ST_OK, 0, 0, 0, 0),
			r_chk(REQ_FIND, 0, VMINV, ST_OK, 0, VMINV, VMAXV, 32'hffff_ffff),
			r_chk(REQ_FIND, 127, VMAXV, ST_OK, 0, VMINV, VMAXV, 32'hffff_ffff),
			r_chk(REQ_READ, 0, 0, ST_OK, 0, VMINV, VMAXV, 32'hffff_ffff),
			r_cfg(0),
			r_pred(REQ_FIND, 0, 32'h1234_5678),
			r_cfg(127),
			r_chk(REQ_FIND, 0, 0, ST_INCOMPLETE, 0, 0, 0, 0),
			r_chk(REQ_READ, 1, 0, ST_INCOMPLETE, 0, 0, 0, 0),
			r_pred(REQ_READ, 0, 0),
			r_chk(REQ_READ, 64, 0, ST_BAD_INDEX, 0, 0, 0, 0),
			r_chk(REQ_WRITE, 65, 0, ST_BAD_INDEX, 0, 0, 0, 0),
			r_cfg(2),
			r_chk(REQ_WRITE, 2, 100, ST_NOT_INCR, 0, 0, 0, 0),
			r_pred(REQ_WRITE, 0, 5),
			r_chk(REQ_FIND, 0, 0, ST_INCOMPLETE, 0, 0, 0, 0),
			r_chk(REQ_WRITE, 1, 5, ST_NOT_INCR, 0, 0, 0, 0),
			r_pred(REQ_WRITE, 1, 6),
			r_pred(REQ_WRITE, 2, 10),
			r_pred(REQ_FIND, 0, 7),
			r_pred(REQ_FIND, 0, 10),
			r_chk(REQ_READ, 127, 0, ST_BAD_INDEX, 0, 0, 0, 0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].is_cfg) begin
				drain();
				write_num_bins(dir_tbl[i].val[NB_W-1:0]);
			end else begin
				issue(dir_tbl[i].req, dir_tbl[i].idx, dir_tbl[i].val, dir_tbl[i].typed,
					dir_tbl[i].ans);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			drain();
			case ($urandom_range(0, 11))
				0: nbv = '0;
				1: nbv = NB_W'(MAX_BINS);
				2: nbv = '1;
				3: nbv = NB_W'($urandom_range(MAX_BINS + 1, 126));
				4: nbv = NB_W'($urandom_range(9, MAX_BINS - 1));
				default: nbv = NB_W'($urandom_range(1, 8));
			endcase
			write_num_bins(nbv);
			idle_on = $urandom_range(0, 2) != 0;
			n = active_bins();
			filled = 1'b0;

			// load a fresh ascending table (not every round), with other requests mixed in, most of them rejected
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 3) == 0) begin
					for (k = 0; k <= n; k++) begin
						gen_bounds[k] = VALUE_WIDTH'(VMIN + ((VMAX - VMIN) * k) / n);
					end
				end else begin
					sm = 1 << $urandom_range(0, 24);
					room = (VMAX - VMIN) - longint'(n) * longint'(sm);
					cur = VMIN + (longint'($urandom) % (room + 1));
					if ($urandom_range(0, 7) == 0) begin
						cur = VMIN;
					end
					for (k = 0; k <= n; k++) begin
						gen_bounds[k] = VALUE_WIDTH'(cur);
						cur = cur + longint'($urandom_range(1, sm));
					end
				end
				gen_top = n;
				for (k = 0; k <= n; k++) begin
					if (k > 0 && $urandom_range(0, 6) == 0) begin
						case ($urandom_range(0, 4))
							0: send(REQ_WRITE, IDX_W'($urandom_range(k + 1, 127)), $urandom);
							1: begin
								d = int'($urandom_range(0, 3));
								cur = longint'(gen_bounds[k - 1]) - d;
								if (cur < VMIN) begin
									cur = VMIN;
								end
								send(REQ_WRITE, IDX_W'(k), VALUE_WIDTH'(cur));
							end
							2: send(REQ_FIND, IDX_W'($urandom), $urandom);
							3: send(REQ_READ, IDX_W'($urandom_range(0, 127)), $urandom);
							default: send(REQ_RSVD, IDX_W'($urandom), $urandom);
						endcase
					end
					send(REQ_WRITE, IDX_W'(k), gen_bounds[k]);
				end
				filled = 1'b1;
			end

			repeat ($urandom_range(8, 40)) begin
				case ($urandom_range(0, 15))
					0, 1, 2, 3, 4, 5, 6, 7, 8: begin
						case ($urandom_range(0, 5))
							0, 1, 2: begin
								k = $urandom_range(0, gen_top);
								d = int'($urandom_range(0, 2)) - 1;
								cur = longint'(gen_bounds[k]) + d;
								if (cur < VMIN) begin
									cur = VMIN;
								end else if (cur > VMAX) begin
									cur = VMAX;
								end
								qv = VALUE_WIDTH'(cur);
							end
							3: qv = $urandom;
							4: qv = VMINV;
							default: qv = VMAXV;
						endcase
						send(REQ_FIND, IDX_W'($urandom), qv);
					end
					9, 10, 11: send(REQ_READ, IDX_W'($urandom_range(0, n)), $urandom);
					12: send(REQ_READ, IDX_W'($urandom_range(0, 127)), $urandom);
					13: send(REQ_RSVD, IDX_W'($urandom), $urandom);
					14: send(REQ_WRITE, IDX_W'($urandom_range(0, 127)), $urandom);
					default: begin
						// rewrite from an earlier edge upward, probing once in between; without a loaded table, just probe once
						if (filled) begin
							j = $urandom_range(0, gen_top);
							for (k = j; k <= gen_top; k++) begin
								send(REQ_WRITE, IDX_W'(k), gen_bounds[k]);
								if (k == j) begin
									send(REQ_FIND, '0, gen_bounds[j]);
								end
							end
						end else begin
							send(REQ_FIND, '0, $urandom);
						end
					end
				endcase
			end
		end

		drain();
		if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
			$display("PASS variable_bin_lookup");
		end else begin
			$display("FAIL variable_bin_lookup");
		end
		$finish;
	end

endmodule

### variable_bin_lookup.f
+incdir+rtl
rtl/vbl_pkg.sv
rtl/vbl_edge_mem.sv
rtl/variable_bin_lookup.sv
tb/tb_variable_bin_lookup.sv
